/* design/cwm_pkg.sv */
// shared types, constants and the microcode program of the client watchdog monitor
// no dependencies; imported by every other module of the block
`default_nettype none

package cwm_pkg;

  // table sizing and field widths
  localparam int unsigned MAX_CLIENTS_DEF = 10;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned CD_W            = 16;
  localparam int unsigned DCNT_W          = 4;
  localparam int unsigned PC_W            = 4;

  typedef logic [PC_W-1:0] pc_t;

  // program addresses
  localparam pc_t PC_TSCAN   = 4'd0;   // tick: walk the table
  localparam pc_t PC_TFIN    = 4'd1;   // tick: decide on the kick
  localparam pc_t PC_CSCAN   = 4'd2;   // check-in: look up the id
  localparam pc_t PC_CDECIDE = 4'd3;   // check-in: found or new
  localparam pc_t PC_CFOUND  = 4'd4;   // check-in: was it defaulted
  localparam pc_t PC_CDEF    = 4'd5;   // check-in: drop the defaulted count
  localparam pc_t PC_CZCHK   = 4'd6;   // check-in: count back at zero
  localparam pc_t PC_CRCHK   = 4'd7;   // check-in: is it the recorded id
  localparam pc_t PC_CSCAN2  = 4'd8;   // check-in: look for another failing client
  localparam pc_t PC_CKICK   = 4'd9;   // check-in: kick and clear record
  localparam pc_t PC_CPICK   = 4'd10;  // check-in: record the other client
  localparam pc_t PC_CRELOAD = 4'd11;  // check-in: reload the countdown
  localparam pc_t PC_CNEW    = 4'd12;  // check-in: append a new client
  localparam pc_t PC_CNONE   = 4'd13;  // check-in: no other failing client

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK_ENT,
    OP_TICK_FIN,
    OP_SAVE_HIT,
    OP_DEC_DCNT,
    OP_KICK_CLR,
    OP_REC_OTHER,
    OP_REC_NONE,
    OP_RELOAD,
    OP_APPEND
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_END,
    CND_MATCH_END,
    CND_CD_NZ,
    CND_DCNT_ZERO,
    CND_NOT_REC,
    CND_FAIL_END
  } cond_e;

  // one control word of the program
  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  loop;
    logic  idx_inc;
    logic  idx_clr;
    logic  done;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic start;
    logic idx_inc;
    logic idx_clr;
    logic emit;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic idx_end;
    logic match;
    logic cd_nz;
    logic dcnt_zero;
    logic not_rec;
    logic other_fail;
    logic out_free;
  } dp_stat_t;

  // one client table entry
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [CD_W-1:0] cd;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // microcode rom
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: CND_NEVER, target: PC_TSCAN,
          loop: 1'b0, idx_inc: 1'b0, idx_clr: 1'b0, done: 1'b0};
    case (pc)
      PC_TSCAN: begin
        w.op = OP_TICK_ENT; w.cond = CND_END; w.target = PC_TFIN;
        w.loop = 1'b1; w.idx_inc = 1'b1;
      end
      PC_TFIN: begin
        w.op = OP_TICK_FIN; w.done = 1'b1;
      end
      PC_CSCAN: begin
        w.cond = CND_MATCH_END; w.target = PC_CDECIDE;
        w.loop = 1'b1; w.idx_inc = 1'b1;
      end
      PC_CDECIDE: begin
        w.op = OP_SAVE_HIT; w.cond = CND_END; w.target = PC_CNEW;
      end
      PC_CFOUND: begin
        w.cond = CND_CD_NZ; w.target = PC_CRELOAD;
      end
      PC_CDEF: begin
        w.op = OP_DEC_DCNT;
      end
      PC_CZCHK: begin
        w.cond = CND_DCNT_ZERO; w.target = PC_CKICK;
      end
      PC_CRCHK: begin
        w.cond = CND_NOT_REC; w.target = PC_CRELOAD; w.idx_clr = 1'b1;
      end
      PC_CSCAN2: begin
        w.cond = CND_FAIL_END; w.target = PC_CPICK;
        w.loop = 1'b1; w.idx_inc = 1'b1;
      end
      PC_CKICK: begin
        w.op = OP_KICK_CLR; w.cond = CND_ALWAYS; w.target = PC_CRELOAD;
      end
      PC_CPICK: begin
        w.op = OP_REC_OTHER; w.cond = CND_END; w.target = PC_CNONE;
      end
      PC_CRELOAD: begin
        w.op = OP_RELOAD; w.done = 1'b1;
      end
      PC_CNEW: begin
        w.op = OP_APPEND; w.done = 1'b1;
      end
      PC_CNONE: begin
        w.op = OP_REC_NONE; w.cond = CND_ALWAYS; w.target = PC_CRELOAD;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/client_watchdog_monitor.sv */
// client_watchdog_monitor: top level; depends on cwm_pkg, cwm_seq, cwm_dp, cwm_table.
// Watches up to MAX_CLIENTS client ids, each with a countdown held in a client table
// that is read one entry per cycle. A tick (func 0) walks the n entries in use; a
// check-in (func 1) looks up its id and, when the client was defaulted, other defaults
// remain and it is the recorded client, walks the table again for another failing
// client. A microcoded sequencer steps through the single read port of the table one
// entry per cycle. One item is worked on at a time; the result sits in an output
// register, so the next item can be taken while it waits. Each item gives exactly one
// result. The reload period register is written through its own port and ignores a
// write of zero; the user must write it only while the block is idle, and the block
// itself does not enforce this.
`default_nettype none

module client_watchdog_monitor #(
  parameter int unsigned MAX_CLIENTS = cwm_pkg::MAX_CLIENTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      func_i,
  input  wire logic [cwm_pkg::ID_W-1:0]  client_id_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           kick_watchdog_o,
  output logic                           fail_record_write_o,
  output logic [cwm_pkg::ID_W-1:0]       fail_record_value_o,
  output logic                           check_in_dropped_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [cwm_pkg::CD_W-1:0]  cfg_data_i
);
  import cwm_pkg::*;

  dp_ctrl_t        ctrl;
  dp_stat_t        stat;
  logic [CD_W-1:0] period_q, period_d;
  logic            in_accept;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // reload period register, zero writes ignored
  always_comb begin
    period_d = period_q;
    if (cfg_valid_i && cfg_ready_o && (cfg_data_i != '0)) begin
      period_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= CD_W'(1);
    end else begin
      period_q <= period_d;
    end
  end

  cwm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cwm_dp #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .client_id_i         (client_id_i),
    .reload_period_i     (period_q),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .kick_watchdog_o     (kick_watchdog_o),
    .fail_record_write_o (fail_record_write_o),
    .fail_record_value_o (fail_record_value_o),
    .check_in_dropped_o  (check_in_dropped_o)
  );

`ifndef SYNTHESIS
  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block not busy after accepting a request");

  // a dropped check-in never kicks or writes the record
  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && check_in_dropped_o) |-> (!kick_watchdog_o && !fail_record_write_o))
    else $error("dropped check-in with kick or record write");

  // a nonzero record value only comes with a record write
  a_value_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fail_record_value_o != '0)) |-> fail_record_write_o)
    else $error("record value without record write");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");
`endif

endmodule

`default_nettype wire

/* design/cwm_table.sv */
// client table: one write port, one registered read port
// depends on cwm_pkg for the entry type
`default_nettype none

module cwm_table #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire cwm_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output cwm_pkg::entry_t      rdata_o
);
  import cwm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/cwm_seq.sv */
// microcode sequencer: step counter, rom lookup, conditional jumps
// depends on cwm_pkg for the program and the control and status structs
`default_nettype none

module cwm_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             func_i,
  output logic                  in_stall_o,
  input  wire cwm_pkg::dp_stat_t stat_i,
  output cwm_pkg::dp_ctrl_t     ctrl_o
);
  import cwm_pkg::*;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  ucode_t     uw;
  logic       taken;
  logic       exec;

  assign uw = ucode_rom(pc_q);

  // jump condition select
  always_comb begin
    case (uw.cond)
      CND_NEVER:     taken = 1'b0;
      CND_ALWAYS:    taken = 1'b1;
      CND_END:       taken = stat_i.idx_end;
      CND_MATCH_END: taken = stat_i.match || stat_i.idx_end;
      CND_CD_NZ:     taken = stat_i.cd_nz;
      CND_DCNT_ZERO: taken = stat_i.dcnt_zero;
      CND_NOT_REC:   taken = stat_i.not_rec;
      CND_FAIL_END:  taken = stat_i.other_fail || stat_i.idx_end;
      default:       taken = 1'b0;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_TSCAN;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // next step and control to the datapath
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    in_stall_o = 1'b1;
    exec       = !uw.done || stat_i.out_free;
    ctrl_o     = '{op: OP_NONE, start: 1'b0, idx_inc: 1'b0, idx_clr: 1'b0, emit: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          pc_d         = func_i ? PC_CSCAN : PC_TSCAN;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        // a final step waits here while the output register is still full and stalled
        if (exec) begin
          ctrl_o.op      = uw.op;
          ctrl_o.idx_clr = uw.idx_clr;
          ctrl_o.idx_inc = uw.idx_inc && !taken;
          ctrl_o.emit    = uw.done;
          if (uw.done) begin
            state_d = ST_IDLE;
          end else if (taken) begin
            pc_d = uw.target;
          end else if (!uw.loop) begin
            pc_d = pc_q + pc_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/cwm_dp.sv */
// datapath: scan index, counters, failure record, result and output registers
// depends on cwm_pkg and instantiates cwm_table
`default_nettype none

module cwm_dp #(
  parameter int unsigned MAX_CLIENTS = cwm_pkg::MAX_CLIENTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cwm_pkg::dp_ctrl_t         ctrl_i,
  output cwm_pkg::dp_stat_t              stat_o,
  input  wire logic [cwm_pkg::ID_W-1:0]  client_id_i,
  input  wire logic [cwm_pkg::CD_W-1:0]  reload_period_i,
  input  wire logic                      out_stall_i,
  output logic                           out_valid_o,
  output logic                           kick_watchdog_o,
  output logic                           fail_record_write_o,
  output logic [cwm_pkg::ID_W-1:0]       fail_record_value_o,
  output logic                           check_in_dropped_o
);
  import cwm_pkg::*;

  localparam int unsigned NW = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  logic [NW-1:0]     idx_q, idx_d;
  logic [NW-1:0]     entries_q, entries_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [ID_W-1:0]   rec_q, rec_d;
  logic [AW-1:0]     hit_q, hit_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic              res_kick_q, res_kick_d;
  logic              res_wr_q, res_wr_d;
  logic [ID_W-1:0]   res_val_q, res_val_d;
  logic              res_drop_q, res_drop_d;
  logic              out_valid_q, out_valid_d;
  logic              out_kick_q, out_kick_d;
  logic              out_wr_q, out_wr_d;
  logic [ID_W-1:0]   out_val_q, out_val_d;
  logic              out_drop_q, out_drop_d;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  entry_t            rdata;
  logic              in_range;

  cwm_table #(
    .DEPTH (MAX_CLIENTS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // read data always belongs to the entry at idx_q
  assign in_range = (idx_q != entries_q);

  // status for the sequencer
  always_comb begin
    stat_o.idx_end    = !in_range;
    stat_o.match      = in_range && (rdata.id == id_q);
    stat_o.cd_nz      = (rdata.cd != '0);
    stat_o.dcnt_zero  = (dcnt_q == '0);
    stat_o.not_rec    = (id_q != rec_q);
    stat_o.other_fail = in_range && (idx_q[AW-1:0] != hit_q) && (rdata.cd == '0);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // operation decode
  always_comb begin
    idx_d      = idx_q;
    entries_d  = entries_q;
    dcnt_d     = dcnt_q;
    rec_d      = rec_q;
    hit_d      = hit_q;
    id_d       = id_q;
    res_kick_d = res_kick_q;
    res_wr_d   = res_wr_q;
    res_val_d  = res_val_q;
    res_drop_d = res_drop_q;
    we         = 1'b0;
    waddr      = idx_q[AW-1:0];
    wdata      = rdata;

    // scan index
    if (ctrl_i.start || ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + NW'(1);
    end

    // new request: capture id, clear result
    if (ctrl_i.start) begin
      id_d       = client_id_i;
      res_kick_d = 1'b0;
      res_wr_d   = 1'b0;
      res_val_d  = '0;
      res_drop_d = 1'b0;
    end

    case (ctrl_i.op)
      OP_TICK_ENT: begin
        if (in_range && (rdata.cd != '0)) begin
          we       = 1'b1;
          waddr    = idx_q[AW-1:0];
          wdata.id = rdata.id;
          wdata.cd = rdata.cd - CD_W'(1);
          if (rdata.cd == CD_W'(1)) begin
            dcnt_d = dcnt_q + DCNT_W'(1);
          end
        end
      end
      OP_TICK_FIN: begin
        res_kick_d = (dcnt_q == '0);
      end
      OP_SAVE_HIT: begin
        hit_d = idx_q[AW-1:0];
      end
      OP_DEC_DCNT: begin
        dcnt_d = dcnt_q - DCNT_W'(1);
      end
      OP_KICK_CLR: begin
        res_kick_d = 1'b1;
        res_wr_d   = 1'b1;
        res_val_d  = '0;
      end
      OP_REC_OTHER: begin
        if (in_range) begin
          rec_d     = rdata.id;
          res_wr_d  = 1'b1;
          res_val_d = rdata.id;
        end
      end
      OP_REC_NONE: begin
        dcnt_d    = '0;
        res_wr_d  = 1'b1;
        res_val_d = '0;
      end
      OP_RELOAD: begin
        we       = 1'b1;
        waddr    = hit_q;
        wdata.id = id_q;
        wdata.cd = reload_period_i;
      end
      OP_APPEND: begin
        if (entries_q != NW'(MAX_CLIENTS)) begin
          we        = 1'b1;
          waddr     = entries_q[AW-1:0];
          wdata.id  = id_q;
          wdata.cd  = reload_period_i;
          entries_d = entries_q + NW'(1);
        end else begin
          res_drop_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kick_d  = out_kick_q;
    out_wr_d    = out_wr_q;
    out_val_d   = out_val_q;
    out_drop_d  = out_drop_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      out_kick_d  = res_kick_d;
      out_wr_d    = res_wr_d;
      out_val_d   = res_val_d;
      out_drop_d  = res_drop_d;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      entries_q   <= '0;
      dcnt_q      <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      entries_q   <= entries_d;
      dcnt_q      <= dcnt_d;
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hit_q      <= hit_d;
    id_q       <= id_d;
    res_kick_q <= res_kick_d;
    res_wr_q   <= res_wr_d;
    res_val_q  <= res_val_d;
    res_drop_q <= res_drop_d;
    out_kick_q <= out_kick_d;
    out_wr_q   <= out_wr_d;
    out_val_q  <= out_val_d;
    out_drop_q <= out_drop_d;
  end

  assign out_valid_o         = out_valid_q;
  assign kick_watchdog_o     = out_kick_q;
  assign fail_record_write_o = out_wr_q;
  assign fail_record_value_o = out_val_q;
  assign check_in_dropped_o  = out_drop_q;

endmodule

`default_nettype wire

/* test/client_watchdog_monitor_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for client_watchdog_monitor: directed table, then random phases
// depends on cwm_pkg and the client_watchdog_monitor RTL; predicts every result in-line

module client_watchdog_monitor_test;

  localparam int unsigned TABLE_DEPTH = cwm_pkg::MAX_CLIENTS_DEF;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 155;

  typedef enum bit {FN_TICK, FN_CHECKIN} func_e;
  typedef enum bit {ROW_ITEM, ROW_CFG} row_e;

  // one response of the block
  typedef struct packed {
    logic                    kick;
    logic                    wr;
    logic [cwm_pkg::ID_W-1:0] val;
    logic                    dropped;
  } outcome_t;

  localparam outcome_t QUIET_RES      = '0;
  localparam outcome_t KICK_RES       = {1'b1, 1'b0, 8'h00, 1'b0};
  localparam outcome_t KICK_CLEAR_RES = {1'b1, 1'b1, 8'h00, 1'b0};
  localparam outcome_t DROP_RES       = {1'b0, 1'b0, 8'h00, 1'b1};

  // one row of the directed plan
  typedef struct {
    row_e                     kind;
    func_e                    fn;
    logic [cwm_pkg::ID_W-1:0] cid;
    logic [cwm_pkg::CD_W-1:0] data;
    bit                       typed;
    outcome_t                 want;
  } row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      func_i;
  logic [cwm_pkg::ID_W-1:0]  client_id_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      kick_watchdog_o;
  logic                      fail_record_write_o;
  logic [cwm_pkg::ID_W-1:0]  fail_record_value_o;
  logic                      check_in_dropped_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [cwm_pkg::CD_W-1:0]  cfg_data_i;

  // predicted watchdog state
  logic [cwm_pkg::ID_W-1:0]   tbl_id [TABLE_DEPTH];
  logic [cwm_pkg::CD_W-1:0]   tbl_cd [TABLE_DEPTH];
  int unsigned                n_used;
  logic [cwm_pkg::DCNT_W-1:0] dflt_cnt;
  logic [cwm_pkg::ID_W-1:0]   fail_id;
  logic [cwm_pkg::CD_W-1:0]   period;

  outcome_t pending_results[$];
  int       fail_count = 0;
  bit       calm = 1'b0;
  int       stall_left = 0;
  bit       stall_now = 1'b0;

  // directed plan: empty table, append, reload, defaults, record handover, full table
  row_t plan [0:24] = '{
    '{ROW_ITEM, FN_TICK,    8'h00, 16'h0000, 1'b1, KICK_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h00, 16'h0000, 1'b1, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'hFF, 16'h0000, 1'b1, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h00, 16'h0000, 1'b1, QUIET_RES},
    '{ROW_ITEM, FN_TICK,    8'h00, 16'h0000, 1'b1, QUIET_RES},
    '{ROW_ITEM, FN_TICK,    8'hFF, 16'h0000, 1'b1, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h00, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'hFF, 16'h0000, 1'b1, KICK_CLEAR_RES},
    '{ROW_CFG,  FN_TICK,    8'h00, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_TICK,    8'h00, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h01, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h02, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h03, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h04, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h05, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h06, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h07, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h08, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'hAA, 16'h0000, 1'b1, DROP_RES},
    '{ROW_CFG,  FN_TICK,    8'h00, 16'hFFFF, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h55, 16'h0000, 1'b1, DROP_RES},
    '{ROW_ITEM, FN_TICK,    8'h00, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'h03, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_ITEM, FN_CHECKIN, 8'hFF, 16'h0000, 1'b0, QUIET_RES},
    '{ROW_CFG,  FN_TICK,    8'h00, 16'h0002, 1'b0, QUIET_RES}
  };

  bit [cwm_pkg::CD_W-1:0] periods [PHASES] = '{1, 3, 16'hFFFF, 0, 2, 5, 1, 7, 2, 4};

  client_watchdog_monitor DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .func_i              (func_i),
    .client_id_i         (client_id_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kick_watchdog_o     (kick_watchdog_o),
    .fail_record_write_o (fail_record_write_o),
    .fail_record_value_o (fail_record_value_o),
    .check_in_dropped_o  (check_in_dropped_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog state update for one request, returns the response it causes
  function automatic outcome_t watchdog_step(func_e fn, logic [cwm_pkg::ID_W-1:0] cid);
    outcome_t res;
    int       n;
    int       k;
    int       hit;
    int       other;
    res = '0;
    n = (n_used > TABLE_DEPTH) ? TABLE_DEPTH : n_used;
    if (fn == FN_TICK) begin
      // every live countdown steps down, each that lands on zero is a new default
      for (k = 0; k < n; k++) begin
        if (tbl_cd[k] != '0) begin
          tbl_cd[k] = tbl_cd[k] - 1'b1;
          if (tbl_cd[k] == '0) dflt_cnt = dflt_cnt + 1'b1;
        end
      end
      res.kick = (dflt_cnt == '0);
    end else begin
      hit = n;
      for (k = 0; k < n; k++) begin
        if (hit == n && tbl_id[k] == cid) hit = k;
      end
      if (hit < n) begin
        // defaulted client coming back
        if (tbl_cd[hit] == '0) begin
          dflt_cnt = dflt_cnt - 1'b1;
          if (dflt_cnt == '0) begin
            res.kick = 1'b1;
            res.wr   = 1'b1;
          end else if (cid == fail_id) begin
            other = n;
            for (k = 0; k < n; k++) begin
              if (other == n && k != hit && tbl_cd[k] == '0) other = k;
            end
            res.wr = 1'b1;
            if (other < n) begin
              fail_id = tbl_id[other];
              res.val = fail_id;
            end else begin
              dflt_cnt = '0;
            end
          end
        end
        tbl_cd[hit] = period;
      end else if (n < TABLE_DEPTH) begin
        tbl_id[n] = cid;
        tbl_cd[n] = period;
        n_used = n + 1;
      end else begin
        res.dropped = 1'b1;
      end
    end
    return res;
  endfunction

  // send one request after a random gap, predict once it is taken
  task automatic issue_request(func_e fn, logic [cwm_pkg::ID_W-1:0] cid, bit typed,
                               outcome_t want);
    int       gap;
    int       r;
    outcome_t res;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= (fn == FN_CHECKIN);
    client_id_i <= cid;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = watchdog_step(fn, cid);
    pending_results.push_back(typed ? want : res);
  endtask

  // hold off until every outstanding response has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // write the reload period while the block is idle
  task automatic write_period(logic [cwm_pkg::CD_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (value != '0) period = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void field_check(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // output stall: short bursts, occasional long ones, quiet in calm phases
  always @(negedge clk_i) begin : stall_gen
    int r;
    if (calm) begin
      stall_now = 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        stall_now = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (r < 92) begin
        stall_now = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_now = 1'b1;
        stall_left = $urandom_range(15, 60);
      end
    end else begin
      stall_left--;
    end
    out_stall_i <= stall_now;
  end

  // compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {kick_watchdog_o, fail_record_write_o, fail_record_value_o, check_in_dropped_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        field_check("kick_watchdog", want.kick, got.kick);
        field_check("fail_record_write", want.wr, got.wr);
        field_check("fail_record_value", want.val, got.val);
        field_check("check_in_dropped", want.dropped, got.dropped);
      end
    end
  end

  // stimulus
  initial begin
    func_e                    fn;
    logic [cwm_pkg::ID_W-1:0] cid;
    int                       r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = 1'b0;
    client_id_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    n_used      = 0;
    dflt_cnt    = '0;
    fail_id     = '0;
    period      = 16'd1;
    foreach (tbl_id[k]) begin
      tbl_id[k] = '0;
      tbl_cd[k] = '0;
    end
    periods[7] = $urandom_range(1, 10);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) write_period(plan[k].data);
      else issue_request(plan[k].fn, plan[k].cid, plan[k].typed, plan[k].want);
    end

    // random phases, each under its own period
    for (int ph = 0; ph < PHASES; ph++) begin
      write_period(periods[ph]);
      calm = (ph % 4 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 79) == 0) settle();
        fn = ($urandom_range(0, 99) < 35) ? FN_TICK : FN_CHECKIN;
        r = $urandom_range(0, 99);
        if (n_used == 0 || r >= 88) cid = $urandom_range(0, 255);
        else if (r < 12) cid = fail_id;
        else cid = tbl_id[$urandom_range(0, n_used - 1)];
        issue_request(fn, cid, 1'b0, QUIET_RES);
      end
    end
    calm = 1'b0;

    settle();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
